@@ rtl/isc_pkg.sv @@
package isc_pkg;

	localparam int CODE_BITS_DEF = 16;
	localparam int UNIT_BITS     = 16;
	localparam int INDEX_BITS    = 12;
	localparam int SLOT_BITS     = 4;

	localparam logic [UNIT_BITS-1:0] CHAR_HASH  = 16'h0023;
	localparam logic [UNIT_BITS-1:0] CHAR_X     = 16'h0078;
	localparam logic [UNIT_BITS-1:0] CHAR_SEMI  = 16'h003B;
	localparam logic [UNIT_BITS-1:0] CHAR_ZERO  = 16'h0030;
	localparam logic [UNIT_BITS-1:0] CHAR_UPPER = 16'h0041;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROCESS = 1'b1;

	localparam logic REG_ESCAPE_MODE = 1'b0;
	localparam logic REG_REPLACEMENT = 1'b1;

	localparam logic [UNIT_BITS-1:0] REPLACEMENT_RESET = 16'd63;

	// escape sequence slots: '#', 'x', four hex digits, ';'
	localparam logic [2:0] STEP_HASH = 3'd0;
	localparam logic [2:0] STEP_X    = 3'd1;
	localparam logic [2:0] STEP_SEMI = 3'd6;

	typedef struct packed {
		logic                  we;
		logic [INDEX_BITS-1:0] wr_index;
		logic [UNIT_BITS-1:0]  wr_word;
		logic                  re;
		logic [INDEX_BITS-1:0] rd_index;
	} bitmap_req_t;

	function automatic logic [UNIT_BITS-1:0] hex_char(input logic [3:0] nibble);
		logic [UNIT_BITS-1:0] ext;
		ext = {12'd0, nibble};
		if (nibble < 4'd10) begin
			return CHAR_ZERO + ext;
		end
		return CHAR_UPPER + ext - 16'd10;
	endfunction

endpackage

@@ rtl/isc_in_if.sv @@
interface isc_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [11:0] table_index;
	logic [15:0] table_word;
	logic [15:0] code_unit;
	logic        end_of_string;

	modport source (
		output valid, operation, table_index, table_word, code_unit, end_of_string,
		input  ready
	);
	modport sink (
		input  valid, operation, table_index, table_word, code_unit, end_of_string,
		output ready
	);
endinterface

@@ rtl/isc_out_if.sv @@
interface isc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_unit;
	logic        last_of_run;
	logic        unit_invalid;
	logic        string_all_valid;

	modport source (
		output valid, out_unit, last_of_run, unit_invalid, string_all_valid,
		input  ready
	);
	modport sink (
		input  valid, out_unit, last_of_run, unit_invalid, string_all_valid,
		output ready
	);
endinterface

@@ rtl/isc_bitmap.sv @@
module isc_bitmap #(
	parameter int ADDR_BITS = isc_pkg::INDEX_BITS
) (
	input  logic                         clk,
	input  isc_pkg::bitmap_req_t         req,
	output logic [isc_pkg::UNIT_BITS-1:0] rd_word
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [isc_pkg::UNIT_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_index[ADDR_BITS-1:0]] <= req.wr_word;
		end
		if (req.re) begin
			rd_word <= mem[req.rd_index[ADDR_BITS-1:0]];
		end
	end

endmodule

@@ rtl/invalid_char_sanitizer_core.sv @@
// Invalid-character sanitizer.
// in_ch carries table loads (operation 0) and code units (operation 1); out_ch
// returns one transfer per emitted unit. A load writes one bitmap word at the
// transfer and produces nothing; the block is ready again in the next cycle.
// A code unit is looked up in the bitmap (one registered read of the bitmap
// memory); S_LOOK then registers its first result into the output register.
// A valid or replaced unit yields one result; an escaped unit yields seven
// results from one output register, one per cycle while out_ch.ready is
// high. in_ch.ready stays low from a code unit transfer until its last
// result is transferred, so a stalled receiver simply holds the block.
// Configuration (escape_mode at 0x0, replacement_char at 0x4) is written over
// the APB port; the user must write it only while idle, as the block itself
// does not enforce this. Reset sets escape_mode to 1, replacement_char to
// 63 and re-arms the string flag; the bitmap is not cleared and must be
// loaded before characters that use it are sent.
module invalid_char_sanitizer_core #(
	parameter int CODE_BITS = isc_pkg::CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	isc_in_if.sink      in_ch,
	isc_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ADDR_BITS = CODE_BITS - isc_pkg::SLOT_BITS;
	localparam logic [isc_pkg::UNIT_BITS-1:0] UNIT_MASK =
		isc_pkg::UNIT_BITS'((32'd1 << CODE_BITS) - 32'd1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                        state_q;
	logic                          esc_q;
	logic [isc_pkg::UNIT_BITS-1:0] repl_q;
	logic                          str_ok_q;
	logic [isc_pkg::UNIT_BITS-1:0] unit_q;
	logic                          eos_q;
	logic [2:0]                    step_q;
	logic [isc_pkg::UNIT_BITS-1:0] sh_q;
	logic                          out_valid_q;
	logic [isc_pkg::UNIT_BITS-1:0] out_unit_q;
	logic                          out_last_q;
	logic                          out_inv_q;
	logic                          out_ok_q;

	isc_pkg::bitmap_req_t          bm_req;
	logic [isc_pkg::UNIT_BITS-1:0] bm_word;
	logic [isc_pkg::UNIT_BITS-1:0] unit_in;
	logic                          in_fire;
	logic                          out_fire;
	logic                          cfg_wr;
	logic                          hit;
	logic                          ok_now;
	logic [2:0]                    step_nx;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b1;
			repl_q <= isc_pkg::REPLACEMENT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				isc_pkg::REG_ESCAPE_MODE: esc_q  <= pwdata[0];
				isc_pkg::REG_REPLACEMENT: repl_q <= pwdata[isc_pkg::UNIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			isc_pkg::REG_ESCAPE_MODE: prdata = {31'd0, esc_q};
			isc_pkg::REG_REPLACEMENT: prdata = {16'd0, repl_q};
			default:                  prdata = '0;
		endcase
	end

	// bitmap access
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign unit_in     = in_ch.code_unit & UNIT_MASK;

	always_comb begin
		bm_req.we       = in_fire && (in_ch.operation == isc_pkg::OP_LOAD) &&
			((in_ch.table_index >> ADDR_BITS) == '0);
		bm_req.wr_index = in_ch.table_index;
		bm_req.wr_word  = in_ch.table_word;
		bm_req.re       = in_fire && (in_ch.operation == isc_pkg::OP_PROCESS);
		bm_req.rd_index = isc_pkg::INDEX_BITS'(unit_in >> isc_pkg::SLOT_BITS);
	end

	isc_bitmap #(
		.ADDR_BITS (ADDR_BITS)
	) u_bitmap (
		.clk     (clk),
		.req     (bm_req),
		.rd_word (bm_word)
	);

	assign hit      = bm_word[unit_q[isc_pkg::SLOT_BITS-1:0]];
	assign ok_now   = str_ok_q && hit;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign step_nx  = step_q + 3'd1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			str_ok_q    <= 1'b1;
			out_valid_q <= 1'b0;
			step_q      <= isc_pkg::STEP_HASH;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_ch.operation == isc_pkg::OP_PROCESS)) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					out_valid_q <= 1'b1;
					step_q      <= isc_pkg::STEP_HASH;
					str_ok_q    <= eos_q || ok_now;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (out_fire) begin
						if (out_last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							step_q <= step_nx;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			unit_q <= unit_in;
			eos_q  <= in_ch.end_of_string;
		end
		if (state_q == S_LOOK) begin
			out_inv_q <= !hit;
			out_ok_q  <= ok_now;
			sh_q      <= unit_q;
			if (hit) begin
				out_unit_q <= unit_q;
				out_last_q <= 1'b1;
			end else if (!esc_q) begin
				out_unit_q <= repl_q;
				out_last_q <= 1'b1;
			end else begin
				out_unit_q <= isc_pkg::CHAR_HASH;
				out_last_q <= 1'b0;
			end
		end else if ((state_q == S_EMIT) && out_fire && !out_last_q) begin
			if (step_nx == isc_pkg::STEP_X) begin
				out_unit_q <= isc_pkg::CHAR_X;
			end else if (step_nx == isc_pkg::STEP_SEMI) begin
				out_unit_q <= isc_pkg::CHAR_SEMI;
				out_last_q <= 1'b1;
			end else begin
				// shift out the next nibble, most significant first
				out_unit_q <= isc_pkg::hex_char(sh_q[15:12]);
				sh_q       <= sh_q << 4;
			end
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.out_unit         = out_unit_q;
	assign out_ch.last_of_run      = out_last_q;
	assign out_ch.unit_invalid     = out_inv_q;
	assign out_ch.string_all_valid = out_ok_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input taken while a result is pending");

	a_valid_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.unit_invalid |-> out_ch.last_of_run)
		else $error("valid unit produced more than one result");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.last_of_run |=> out_ch.valid)
		else $error("escape sequence broken off");

	a_escape_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (step_q == isc_pkg::STEP_HASH) && !out_ch.last_of_run
		|-> out_ch.out_unit == isc_pkg::CHAR_HASH)
		else $error("escape does not start with hash");

	a_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_ch.operation == isc_pkg::OP_PROCESS) |=> state_q == S_LOOK)
		else $error("code unit transfer did not start a lookup");

endmodule
